// ----- src/mec_pkg.sv -----
package mec_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TEST,
    ST_COLOUR,
    ST_DIV,
    ST_DONE
  } state_t;

  // configuration register indexes
  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_RADIUS   = 1'b1;

  localparam int unsigned ZW      = 32;
  localparam int unsigned RADIUS_W = 36;

  // colour numerator weights
  localparam longint unsigned K_BASE  = 40000;
  localparam longint unsigned K_RED   = 128033;
  localparam longint unsigned K_GRN_U = 42964;
  localparam longint unsigned K_GRN_V = 38059;
  localparam longint unsigned K_BLUE  = 425596;

  // control from the sequencer to the multiplier
  typedef struct packed {
    logic start;
  } mul_ctl_t;

endpackage

// ----- src/mec_if.sv -----
interface mec_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  modport source (output valid, c_real, c_imag, input ready);
  modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface mec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] iteration_count;
  logic        in_set;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  modport source (output valid, iteration_count, in_set, red, green, blue, input ready);
  modport sink   (input valid, iteration_count, in_set, red, green, blue, output ready);
endinterface

// ----- src/mec_sermul.sv -----
// Shift-add signed multiplier, one multiplier bit per cycle.
module mec_sermul (
  input  logic               clk,
  input  logic               rst_n,
  input  mec_pkg::mul_ctl_t  ctl,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [63:0] p
);
  logic signed [63:0] acc_r, acc_nxt;
  logic        [31:0] mb_r, mb_nxt;
  logic signed [63:0] ma_r, ma_nxt;
  logic        [5:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;

  // one partial product per cycle; the sign bit has negative weight
  always_comb begin
    acc_nxt  = acc_r;
    mb_nxt   = mb_r;
    ma_nxt   = ma_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      acc_nxt  = '0;
      mb_nxt   = b;
      ma_nxt   = 64'(a);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mb_r[0]) begin
        if (cnt_r == 6'd31) acc_nxt = acc_r - ma_r;
        else                acc_nxt = acc_r + ma_r;
      end
      mb_nxt  = mb_r >> 1;
      ma_nxt  = ma_r <<< 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mb_r  <= mb_nxt;
    ma_r  <= ma_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd31);
  assign p    = acc_nxt;
endmodule

// ----- src/mec_serdiv.sv -----
// Restoring divider, one quotient bit per cycle; quotient saturated to 8 bits.
module mec_serdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [7:0]  q
);
  logic [63:0] n_r, n_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [39:0] den_r;
  logic [40:0] trial;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[39:0], n_r[63]};
    if (start) begin
      n_nxt    = num;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) den_r <= den;
  end

  assign done = busy_r && (cnt_r == 7'd63);
  assign q    = (q_nxt > 64'd255) ? 8'hFF : q_nxt[7:0];
endmodule

// ----- src/mandelbrot_escape_color.sv -----
// Channel | Direction | Payload
// in_     | sink      | c_real, c_imag (Q4.28)
// out_    | source    | iteration_count, in_set, red, green, blue
// cfg_    | write     | 0 max_iterations, 1 escape_radius_squared
// One point at a time. Each update takes three serial products (zr*zi, zr*zr,
// zi*zi), each preceded by a start strobe, and one test; then three serial
// divisions for the colour when the point escapes.
// Synchronous active-low reset; registers return to 256 and 2^30.
// A new point is taken while a result waits; a finished point holds until the
// output register is free.
module mandelbrot_escape_color #(
  parameter int unsigned FRAC_BITS   = 28,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mec_in_if.sink      in_ch,
  mec_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [35:0] cfg_data
);
  localparam logic [COUNT_WIDTH-1:0] CMASK = {COUNT_WIDTH{1'b1}};

  mec_pkg::state_t st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] maxit_r;
  logic [35:0]            rad_r;
  logic signed [31:0]     cr_r, ci_r, zr_r, zi_r, ma, mb;
  logic signed [63:0]     rr_r, ii_r, prod;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [1:0]             ph_r;
  logic                   over_r, mdone, mstart, ddone, dstart;
  logic                   mkick_r, mkick_nxt, oload;
  mec_pkg::mul_ctl_t      mctl;
  logic [7:0]             dq, red_r, grn_r, blu_r;
  logic [7:0]             ored_r, ogrn_r, oblu_r;
  logic [15:0]            ocnt_r;
  logic                   oset_r, ovld_r;
  logic signed [64:0]     nr_w, ni_w, magx;
  logic [63:0]            mag;
  logic signed [63:0]     dr, dn;
  logic signed [47:0]     nred, ngrn, nblu;
  logic [63:0]            dnum;
  logic [39:0]            dden;
  logic [COUNT_WIDTH:0]   cnt_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxit_r <= COUNT_WIDTH'(256) & CMASK;
      rad_r   <= 36'd1073741824;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mec_pkg::CFG_MAX_ITER: maxit_r <= COUNT_WIDTH'(cfg_data[15:0]);
        mec_pkg::CFG_RADIUS:   rad_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection per product phase: 0 zr*zr, 1 zi*zi, 2 zr*zi
  always_comb begin
    unique case (ph_r)
      2'd0:    begin ma = zr_r; mb = zr_r; end
      2'd1:    begin ma = zi_r; mb = zi_r; end
      default: begin ma = zr_r; mb = zi_r; end
    endcase
  end

  assign mctl.start = mstart;
  mec_sermul u_mul (.clk, .rst_n, .ctl(mctl), .a(ma), .b(mb), .done(mdone), .p(prod));

  // update arithmetic from the three products (ri is prod in phase 2)
  assign dr   = rr_r - ii_r;
  assign nr_w = 65'(dr >>> FRAC_BITS) + 65'(cr_r);
  assign ni_w = 65'(prod >>> (FRAC_BITS - 1)) + 65'(ci_r);
  assign magx = 65'(rr_r) + 65'(ii_r);
  assign mag  = 64'(magx);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  // colour numerators: 2n-m in signed arithmetic
  assign dn   = 64'(2 * {48'd0, cnt_r}) - 64'({48'd0, maxit_r});
  assign nred = 48'(255 * (64'(mec_pkg::K_BASE) * 64'(maxit_r) - 64'(mec_pkg::K_RED) * dn));
  assign ngrn = 48'(255 * (64'(mec_pkg::K_BASE) * 64'(maxit_r)
                  - 64'(mec_pkg::K_GRN_U) * dn + 64'(mec_pkg::K_GRN_V) * dn));
  assign nblu = 48'(255 * (64'(mec_pkg::K_BASE) * 64'(maxit_r) + 64'(mec_pkg::K_BLUE) * dn));
  assign dden = 40'(200000 * 64'(maxit_r));

  always_comb begin
    unique case (ph_r)
      2'd0:    dnum = nred[47] ? 64'd0 : 64'(nred);
      2'd1:    dnum = ngrn[47] ? 64'd0 : 64'(ngrn);
      default: dnum = nblu[47] ? 64'd0 : 64'(nblu);
    endcase
  end

  mec_serdiv u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                    .done(ddone), .q(dq));

  // a finished point moves to the output register once it is free
  assign oload = (st_r == mec_pkg::ST_DONE) && (!ovld_r || out_ch.ready);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mec_pkg::ST_IDLE:   if (in_ch.valid) st_nxt = mec_pkg::ST_TEST;
      mec_pkg::ST_MUL:    if (mdone && ph_r == 2'd1) st_nxt = mec_pkg::ST_TEST;
      mec_pkg::ST_TEST: begin
        if (over_r || (mag >> FRAC_BITS) > 64'(rad_r) || cnt_r >= maxit_r) begin
          if (cnt_r == maxit_r) st_nxt = mec_pkg::ST_DONE;
          else                  st_nxt = mec_pkg::ST_COLOUR;
        end else begin
          st_nxt = mec_pkg::ST_MUL;
        end
      end
      mec_pkg::ST_COLOUR: st_nxt = mec_pkg::ST_DIV;
      mec_pkg::ST_DIV:    if (ddone) st_nxt = (ph_r == 2'd2) ? mec_pkg::ST_DONE
                                                            : mec_pkg::ST_COLOUR;
      mec_pkg::ST_DONE:   if (oload) st_nxt = mec_pkg::ST_IDLE;
      default:            st_nxt = mec_pkg::ST_IDLE;
    endcase
  end

  // multiplier start is registered, so it arrives together with the updated operands
  assign mkick_nxt = ((st_r == mec_pkg::ST_TEST) && (st_nxt == mec_pkg::ST_MUL)) ||
                     ((st_r == mec_pkg::ST_MUL) && mdone && (ph_r != 2'd1));

  // unit start strobes
  always_comb begin
    mstart = mkick_r;
    dstart = 1'b0;
    unique case (st_r)
      mec_pkg::ST_COLOUR: dstart = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = (st_r == mec_pkg::ST_IDLE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= mec_pkg::ST_IDLE;
      ovld_r  <= 1'b0;
      ph_r    <= '0;
      mkick_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mkick_r <= mkick_nxt;
      if (oload) ovld_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovld_r <= 1'b0;
      unique case (st_r)
        mec_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          cr_r <= in_ch.c_real; ci_r <= in_ch.c_imag;
          zr_r <= '0; zi_r <= '0; cnt_r <= '0; over_r <= 1'b0;
          rr_r <= '0; ii_r <= '0;
        end
        mec_pkg::ST_MUL: if (mdone) begin
          unique case (ph_r)
            2'd0: begin rr_r <= prod; ph_r <= 2'd1; end
            2'd1: ii_r <= prod;
            default: begin
              cnt_r <= COUNT_WIDTH'(cnt_inc);
              if (nr_w > 65'sd2147483647 || nr_w < -65'sd2147483648 ||
                  ni_w > 65'sd2147483647 || ni_w < -65'sd2147483648) begin
                over_r <= 1'b1;
              end else begin
                zr_r <= 32'(nr_w); zi_r <= 32'(ni_w);
              end
              ph_r <= 2'd0;
            end
          endcase
        end
        mec_pkg::ST_TEST: if (st_nxt == mec_pkg::ST_COLOUR) begin
          ph_r <= 2'd0;
        end else if (st_nxt == mec_pkg::ST_MUL) begin
          ph_r <= 2'd2;
        end
        mec_pkg::ST_DIV: if (ddone) begin
          unique case (ph_r)
            2'd0:    red_r <= dq;
            2'd1:    grn_r <= dq;
            default: blu_r <= dq;
          endcase
          ph_r <= ph_r + 2'd1;
        end
        mec_pkg::ST_DONE: if (oload) begin
          ocnt_r <= 16'(cnt_r);
          oset_r <= (cnt_r == maxit_r);
          if (cnt_r == maxit_r) begin
            ored_r <= '0; ogrn_r <= '0; oblu_r <= '0;
          end else begin
            ored_r <= red_r; ogrn_r <= grn_r; oblu_r <= blu_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = ovld_r;
  assign out_ch.iteration_count = ocnt_r;
  assign out_ch.in_set          = oset_r;
  assign out_ch.red             = ored_r;
  assign out_ch.green           = ogrn_r;
  assign out_ch.blue            = oblu_r;
endmodule
